/* rtl/epm_pkg.sv */
// Shared types, codes and character helpers for the escape pattern matcher.
package epm_pkg;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 6;
    localparam int PAT_SLOTS   = 32;
    localparam int PAT_BITS    = PAT_SLOTS * CHAR_W;
    localparam int SLOT_W      = $clog2(PAT_SLOTS);
    localparam int WORD_W      = 64;
    localparam int REG_IDX_W   = 3;
    localparam int ADDR_W      = 6;

    // Operation codes of a subject request.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Register indexes (byte address / 8).
    localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd4;

    // Characters with meaning in the pattern or the subject.
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25; // '%'
    localparam logic [CHAR_W-1:0] CH_LC_C  = 8'h63; // 'c'
    localparam logic [CHAR_W-1:0] CH_LC_N  = 8'h6E; // 'n'
    localparam logic [CHAR_W-1:0] CH_UC_N  = 8'h4E; // 'N'
    localparam logic [CHAR_W-1:0] CH_LC_M  = 8'h6D; // 'm'
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61; // 'a'
    localparam logic [CHAR_W-1:0] CH_LC_P  = 8'h70; // 'p'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E; // '.'
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_DIGITS = 3'd1,
        MODE_NSIGN  = 3'd2,
        MODE_NBODY  = 3'd3,
        MODE_REST   = 3'd4
    } mode_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        mode_t            mode;
        logic             dot_seen;
        logic             prev_dot;
        logic             failed;
    } match_state_t;

    localparam match_state_t STATE_CLEAR = '{
        pos:      '0,
        mode:     MODE_NORMAL,
        dot_seen: 1'b0,
        prev_dot: 1'b0,
        failed:   1'b0
    };

    function automatic logic [CHAR_W-1:0] pat_char(
        input logic [PAT_BITS-1:0] chars,
        input logic [SLOT_W-1:0]   idx
    );
        return chars[idx*CHAR_W +: CHAR_W];
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic known_escape(input logic [CHAR_W-1:0] e);
        return (e == CH_LC_C) || (e == CH_LC_N) || (e == CH_LC_P) ||
               (e == CH_LC_M) || (e == CH_UC_N) || (e == CH_LC_A);
    endfunction

endpackage

/* rtl/epm_if.sv */
// Valid/ready channel interfaces for subject requests and match results.
interface epm_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink (input valid, input op, input ch, output ready);
endinterface

interface epm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic bad_pattern;

    modport source (output valid, output matched, output bad_pattern, input ready);
    modport sink (input valid, input matched, input bad_pattern, output ready);
endinterface

/* rtl/epm_step.sv */
// Next-state and result logic for one subject request, plus pattern validity check.
module epm_step
    import epm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  match_state_t           cur,
    input  logic                   op,
    input  logic [CHAR_W-1:0]      ch,
    input  logic [PAT_BITS-1:0]    pat_chars,
    input  logic [POS_W-1:0]       used_len,
    output match_state_t           nxt,
    output logic                   res_matched,
    output logic                   res_bad
);

    logic [CHAR_W-1:0] lit;
    logic [CHAR_W-1:0] esc;
    logic [POS_W-1:0]  pos_p1;
    logic [POS_W-1:0]  pos_p2;
    match_state_t      m_state;
    logic              bad;

    // Pattern validity: a '%' in use whose follower is missing or unknown.
    always_comb
    begin
        bad = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((POS_W'(i) < used_len) &&
                (pat_char(pat_chars, SLOT_W'(i)) == CH_PCT) &&
                ((POS_W'(i + 1) >= used_len) ||
                 !known_escape(pat_char(pat_chars, SLOT_W'(i + 1)))))
            begin
                bad = 1'b1;
            end
        end
    end

    assign pos_p1 = cur.pos + POS_W'(1);
    assign pos_p2 = cur.pos + POS_W'(2);
    assign lit    = pat_char(pat_chars, cur.pos[SLOT_W-1:0]);
    assign esc    = pat_char(pat_chars, pos_p1[SLOT_W-1:0]);

    // Match the character against the element at the current position.
    always_comb
    begin
        m_state      = cur;
        m_state.mode = MODE_NORMAL;
        if (cur.pos >= used_len)
        begin
            m_state.failed = 1'b1;
        end
        else if (lit != CH_PCT)
        begin
            if (ch == lit)
                m_state.pos = pos_p1;
            else
                m_state.failed = 1'b1;
        end
        else if (pos_p1 >= used_len)
        begin
            m_state.failed = 1'b1;
        end
        else
        begin
            unique case (esc)
                CH_LC_C:
                begin
                    if (is_letter(ch)) m_state.pos = pos_p2;
                    else               m_state.failed = 1'b1;
                end
                CH_LC_N:
                begin
                    if (is_digit(ch)) m_state.pos = pos_p2;
                    else              m_state.failed = 1'b1;
                end
                CH_LC_P:
                begin
                    if (ch == CH_PCT) m_state.pos = pos_p2;
                    else              m_state.failed = 1'b1;
                end
                CH_LC_M:
                begin
                    if (is_digit(ch))
                    begin
                        m_state.pos  = pos_p2;
                        m_state.mode = MODE_DIGITS;
                    end
                    else
                    begin
                        m_state.failed = 1'b1;
                    end
                end
                CH_UC_N:
                begin
                    m_state.dot_seen = 1'b0;
                    m_state.prev_dot = 1'b0;
                    if ((ch == CH_MINUS) || (ch == CH_PLUS))
                    begin
                        m_state.pos  = pos_p2;
                        m_state.mode = MODE_NSIGN;
                    end
                    else if (is_digit(ch))
                    begin
                        m_state.pos  = pos_p2;
                        m_state.mode = MODE_NBODY;
                    end
                    else
                    begin
                        m_state.failed = 1'b1;
                    end
                end
                CH_LC_A:
                begin
                    m_state.pos  = pos_p2;
                    m_state.mode = MODE_REST;
                end
                default:
                begin
                    m_state.failed = 1'b1;
                end
            endcase
        end
    end

    // Run handling, end-of-subject verdict.
    always_comb
    begin
        nxt         = cur;
        res_matched = 1'b0;
        res_bad     = bad;
        if (op == OP_END)
        begin
            res_matched = !cur.failed && !bad && (used_len != '0) &&
                          (cur.pos == used_len) && (cur.mode != MODE_NSIGN) &&
                          !((cur.mode == MODE_NBODY) && cur.prev_dot);
            nxt = STATE_CLEAR;
        end
        else if (!cur.failed)
        begin
            unique case (cur.mode)
                MODE_DIGITS:
                begin
                    if (!is_digit(ch)) nxt = m_state;
                end
                MODE_NSIGN:
                begin
                    if (is_digit(ch)) nxt.mode = MODE_NBODY;
                    else              nxt.failed = 1'b1;
                end
                MODE_NBODY:
                begin
                    if (is_digit(ch))
                    begin
                        nxt.prev_dot = 1'b0;
                    end
                    else if (ch == CH_DOT)
                    begin
                        if (cur.dot_seen)
                        begin
                            nxt.failed = 1'b1;
                        end
                        else
                        begin
                            nxt.dot_seen = 1'b1;
                            nxt.prev_dot = 1'b1;
                        end
                    end
                    else if (cur.prev_dot)
                    begin
                        nxt.failed = 1'b1;
                    end
                    else
                    begin
                        nxt          = m_state;
                        nxt.dot_seen = 1'b0;
                        if (m_state.mode == MODE_NBODY || m_state.mode == MODE_NSIGN)
                            nxt.dot_seen = m_state.dot_seen;
                    end
                end
                MODE_REST:
                begin
                    nxt = cur;
                end
                default:
                begin
                    nxt = m_state;
                end
            endcase
        end
    end

endmodule

/* rtl/escape_pattern_text_matcher.sv */
// Top level: configuration registers, input stage, match state and result register.
// Flow: an accepted request is held in the input stage and processed from there, and an
//   end-of-subject result is then loaded into the result register that drives result_out.
// Throughput: one request per cycle, but an end request stalls while an untaken result is held.
// Reset (rst_n low, asynchronous): pattern registers and length clear to zero,
//   match state returns to the start of a subject, both channels go empty.
module escape_pattern_text_matcher
    import epm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready,
    epm_in_if.sink              text_in,
    epm_out_if.source           result_out
);

    localparam logic [POS_W-1:0] LEN_CAP = POS_W'(PATTERN_MAX);

    // Configuration.
    logic [PAT_BITS-1:0]  pat_reg;
    logic [PAT_BITS-1:0]  pat_next;
    logic [POS_W-1:0]     len_reg;
    logic [POS_W-1:0]     len_next;
    logic [POS_W-1:0]     used_len;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    // Input stage.
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_op_reg;
    logic [CHAR_W-1:0]    s1_ch_reg;
    logic                 s1_fire;
    logic                 in_take;

    // Match state and result register.
    match_state_t         state_reg;
    match_state_t         state_next;
    match_state_t         step_state;
    logic                 step_matched;
    logic                 step_bad;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 matched_reg;
    logic                 bad_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    // Clamp the length to the pattern capacity.
    assign used_len = (len_reg > LEN_CAP) ? LEN_CAP : len_reg;

    // Register write decode; unmapped addresses are dropped.
    always_comb
    begin
        pat_next = pat_reg;
        len_next = len_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PAT0: pat_next[0*WORD_W +: WORD_W] = pwdata;
                REG_PAT1: pat_next[1*WORD_W +: WORD_W] = pwdata;
                REG_PAT2: pat_next[2*WORD_W +: WORD_W] = pwdata;
                REG_PAT3: pat_next[3*WORD_W +: WORD_W] = pwdata;
                REG_LEN:  len_next = pwdata[POS_W-1:0];
                default:  len_next = len_reg;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_PAT0: prdata = pat_reg[0*WORD_W +: WORD_W];
            REG_PAT1: prdata = pat_reg[1*WORD_W +: WORD_W];
            REG_PAT2: prdata = pat_reg[2*WORD_W +: WORD_W];
            REG_PAT3: prdata = pat_reg[3*WORD_W +: WORD_W];
            REG_LEN:  prdata = {{(WORD_W-POS_W){1'b0}}, len_reg};
            default:  prdata = '0;
        endcase
    end

    // Advance the held request unless it would overwrite an untaken result.
    assign s1_fire = s1_valid_reg &&
                     ((s1_op_reg == OP_CHAR) || !out_valid_reg || result_out.ready);
    assign text_in.ready = !s1_valid_reg || s1_fire;
    assign in_take       = text_in.valid && text_in.ready;

    epm_step #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_step (
        .cur         (state_reg),
        .op          (s1_op_reg),
        .ch          (s1_ch_reg),
        .pat_chars   (pat_reg),
        .used_len    (used_len),
        .nxt         (step_state),
        .res_matched (step_matched),
        .res_bad     (step_bad)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        state_next = s1_fire ? step_state : state_reg;

        // Load a result on end of subject, drop it once taken.
        out_valid_next = out_valid_reg;
        if (s1_fire && (s1_op_reg == OP_END))
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg       <= '0;
            len_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pat_reg       <= pat_next;
            len_reg       <= len_next;
            s1_valid_reg  <= s1_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold the request and the result without reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg <= text_in.op;
            s1_ch_reg <= text_in.ch;
        end
        if (s1_fire && (s1_op_reg == OP_END))
        begin
            matched_reg <= step_matched;
            bad_reg     <= step_bad;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.matched     = matched_reg;
    assign result_out.bad_pattern = bad_reg;

endmodule
